[rtl/pua_pkg.sv]
// Shared types, constants and helpers for the polar unwrap address generator.
// No dependencies.
package pua_pkg;

  localparam int SRC_COL_BITS = 11;
  localparam int SRC_ROW_BITS = 11;
  localparam int FRAC_BITS    = 16;

  localparam logic [13:0] MAX_WIDTH   = 14'd8192;
  localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;

  // pipeline stage numbering
  localparam int DIV_STEPS = 16;
  localparam int ST_DIV0   = 1;
  localparam int ST_PHASE  = ST_DIV0 + DIV_STEPS;
  localparam int ST_SIN0   = ST_PHASE + 1;
  localparam int SIN_STG   = 7;
  localparam int ST_CRD0   = ST_SIN0 + SIN_STG;
  localparam int CRD_STG   = 4;
  localparam int ST_LAST   = ST_CRD0 + CRD_STG - 1;

  typedef logic signed [33:0] poly_t;
  typedef logic signed [17:0] trig_t;

  localparam poly_t C1 = 34'sd1686629713;
  localparam poly_t C3 = -34'sd693598668;
  localparam poly_t C5 = 34'sd85569306;
  localparam poly_t C7 = -34'sd5026995;
  localparam poly_t C9 = 34'sd172272;

  localparam poly_t HORNER_C [4] = '{C7, C5, C3, C1};

  typedef enum logic [2:0] {
    REG_OUT_WIDTH   = 3'd0,
    REG_CENTER_U    = 3'd1,
    REG_CENTER_V    = 3'd2,
    REG_INNER_DIAM  = 3'd3,
    REG_OUTER_DIAM  = 3'd4,
    REG_ANGLE_OFS   = 3'd5,
    REG_ASPECT      = 3'd6
  } cfg_idx_t;

  // Q30 product, truncated toward zero
  function automatic poly_t mul_q30(poly_t a, logic [30:0] b);
    logic [33:0] mag;
    logic [64:0] prod;
    logic [33:0] sh;
    mag  = a[33] ? 34'(-a) : 34'(a);
    prod = 65'(mag) * 65'(b);
    sh   = prod[63:30];
    return a[33] ? poly_t'(-sh) : poly_t'(sh);
  endfunction

endpackage

[rtl/polar_unwrap_address_generator.sv]
// Top level of the polar unwrap address generator: configuration registers,
// input saturation, radius interpolation and the pipeline control.
// Depends on pua_pkg, pua_div, pua_sin and pua_crd.
//
// Usage:
//  Input channel (in_valid/in_stall, out_row/out_col) names one output pixel.
//  Result channel (out_valid/out_stall) returns src_x, src_y, the byte offset
//  of the 3-byte source pixel and the clamped flag, in input order.
//  The datapath is a 29-stage pipeline, and one item can transfer every cycle
//  while out_stall is low. The depth is set by stage 0 saturation, the 16-step
//  divider, the phase stage, the Horner multiply chain of the sine lanes and the coordinate stages.
//  When out_stall is high the held result stays put, stages behind it close
//  up their bubbles, and in_stall rises only once every stage holds an item.
//  Configuration writes (cfg_valid/cfg_ready, always ready) are read by the
//  stages directly, also for items in flight; write only while the pipeline is empty.
//  rst (synchronous) empties the pipeline and loads the default registers.
module polar_unwrap_address_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [10:0] out_row,
  input  logic [12:0] out_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] src_x,
  output logic [10:0] src_y,
  output logic [23:0] src_byte_offset,
  output logic        clamped
);
  import pua_pkg::*;

  logic [15:0] center_u;
  logic [15:0] center_v;
  logic [16:0] inner_diameter;
  logic [16:0] outer_diameter;
  logic [15:0] angle_offset;
  logic [15:0] aspect_ratio;

  logic [13:0] w_c;
  logic [10:0] h;
  logic [13:0] w_c_next;
  logic [43:0] h_prod;

  logic [ST_LAST:0] valid;
  logic [ST_LAST:0] en;

  logic [10:0] row_s0;
  logic [12:0] col_s0;
  logic [ST_CRD0-1:0] flag_d;

  logic [15:0] cf;
  logic [15:0] rf;
  logic [15:0] phase;
  logic [33:0] p_in;
  logic [33:0] p_out;
  logic [34:0] amp_sum;
  logic [15:0] amp_d [ST_SIN0:ST_CRD0-1];
  trig_t       sv;
  trig_t       cv;

  assign cfg_ready = 1'b1;

  // derived width and height
  assign w_c_next = (cfg_data[13:0] > MAX_WIDTH) ? MAX_WIDTH : cfg_data[13:0];
  assign h_prod   = 44'(w_c_next) * 44'(INV_2PI_Q32);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_c            <= 14'd4096;
      h              <= 11'd651;
      center_u       <= 16'd32768;
      center_v       <= 16'd32768;
      inner_diameter <= 17'd16384;
      outer_diameter <= 17'd65536;
      angle_offset   <= '0;
      aspect_ratio   <= 16'd16384;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_OUT_WIDTH: begin
          w_c <= w_c_next;
          h   <= h_prod[42:32];
        end
        REG_CENTER_U:   center_u       <= cfg_data[15:0];
        REG_CENTER_V:   center_v       <= cfg_data[15:0];
        REG_INNER_DIAM: inner_diameter <= cfg_data;
        REG_OUTER_DIAM: outer_diameter <= cfg_data;
        REG_ANGLE_OFS:  angle_offset   <= cfg_data[15:0];
        REG_ASPECT:     aspect_ratio   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage moves when empty or when the one after it moves
  always_comb begin
    en[ST_LAST] = !valid[ST_LAST] || !out_stall;
    for (int k = ST_LAST - 1; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = valid[ST_LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k <= ST_LAST; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // stage 0: saturate row and column
  always_ff @(posedge clk) begin
    if (en[0]) begin
      row_s0    <= ({1'b0, out_row} >= {1'b0, h}) ? ((h != '0) ? 11'(h - 11'd1) : '0)
                                                   : out_row;
      col_s0    <= ({1'b0, out_col} >= w_c) ? ((w_c != '0) ? 13'(w_c - 14'd1) : '0)
                                             : out_col;
      flag_d[0] <= ({1'b0, out_row} >= {1'b0, h}) || ({1'b0, out_col} >= w_c);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k < ST_CRD0; k++) begin
      if (en[k]) begin
        flag_d[k] <= flag_d[k-1];
      end
    end
  end

  pua_div u_div (
    .clk (clk),
    .en  (en[ST_PHASE-1:ST_DIV0]),
    .col (col_s0),
    .row (row_s0),
    .w_c (w_c),
    .h   (h),
    .cf  (cf),
    .rf  (rf)
  );

  // phase and radius products
  always_ff @(posedge clk) begin
    if (en[ST_PHASE]) begin
      phase <= cf + angle_offset;
      p_in  <= 34'(inner_diameter) * 34'(17'(17'h10000 - {1'b0, rf}));
      p_out <= 34'(outer_diameter) * 34'({1'b0, rf});
    end
  end

  assign amp_sum = 35'(p_in) + 35'(p_out);

  always_ff @(posedge clk) begin
    if (en[ST_SIN0]) begin
      amp_d[ST_SIN0] <= amp_sum[32:17];
    end
    for (int k = ST_SIN0 + 1; k < ST_CRD0; k++) begin
      if (en[k]) begin
        amp_d[k] <= amp_d[k-1];
      end
    end
  end

  pua_sin u_sin (
    .clk   (clk),
    .en    (en[ST_CRD0-1:ST_SIN0]),
    .phase (phase),
    .sv    (sv)
  );

  pua_sin u_cos (
    .clk   (clk),
    .en    (en[ST_CRD0-1:ST_SIN0]),
    .phase (16'(phase + 16'h4000)),
    .sv    (cv)
  );

  pua_crd u_crd (
    .clk             (clk),
    .en              (en[ST_LAST:ST_CRD0]),
    .sv              (sv),
    .cv              (cv),
    .amp             (amp_d[ST_CRD0-1]),
    .flag_in         (flag_d[ST_CRD0-1]),
    .center_u        (center_u),
    .center_v        (center_v),
    .aspect_ratio    (aspect_ratio),
    .src_x           (src_x),
    .src_y           (src_y),
    .src_byte_offset (src_byte_offset),
    .clamped         (clamped)
  );

`ifndef SYNTH
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&valid))
    else $error("input stalled with a free pipeline stage");

  a_offset_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (src_byte_offset == ({2'b0, src_y, src_x} * 24'd3)))
    else $error("byte offset does not match coordinates");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (valid[ST_LAST-1] && !out_stall) |=> out_valid)
    else $error("result lost at the output stage");
`endif

endmodule

[rtl/pua_div.sv]
// Pipelined restoring divider: angle and radius fractions, one quotient bit a stage.
// Depends on pua_pkg.
module pua_div (
  input  logic                          clk,
  input  logic [pua_pkg::DIV_STEPS-1:0] en,
  input  logic [12:0]                   col,
  input  logic [10:0]                   row,
  input  logic [13:0]                   w_c,
  input  logic [10:0]                   h,
  output logic [15:0]                   cf,
  output logic [15:0]                   rf
);
  import pua_pkg::*;

  logic [13:0] crem [0:DIV_STEPS];
  logic [10:0] rrem [0:DIV_STEPS];
  logic [15:0] cq   [0:DIV_STEPS];
  logic [15:0] rq   [0:DIV_STEPS];

  assign crem[0] = {1'b0, col};
  assign rrem[0] = row;
  assign cq[0]   = '0;
  assign rq[0]   = '0;

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [14:0] csh;
    logic [11:0] rsh;
    logic        cge;
    logic        rge;
    assign csh = {crem[k-1], 1'b0};
    assign rsh = {rrem[k-1], 1'b0};
    assign cge = (csh >= {1'b0, w_c}) && (w_c != '0);
    assign rge = (rsh >= {1'b0, h}) && (h != '0);
    always_ff @(posedge clk) begin
      if (en[k-1]) begin
        crem[k] <= cge ? 14'(csh - {1'b0, w_c}) : csh[13:0];
        rrem[k] <= rge ? 11'(rsh - {1'b0, h}) : rsh[10:0];
        cq[k]   <= {cq[k-1][14:0], cge};
        rq[k]   <= {rq[k-1][14:0], rge};
      end
    end
  end

  assign cf = cq[DIV_STEPS];
  assign rf = rq[DIV_STEPS];

endmodule

[rtl/pua_sin.sv]
// Fixed-point sine lane: quadrant fold, Horner polynomial, at most one multiply a stage.
// Depends on pua_pkg.
module pua_sin (
  input  logic                        clk,
  input  logic [pua_pkg::SIN_STG-1:0] en,
  input  logic [15:0]                 phase,
  output pua_pkg::trig_t              sv
);
  import pua_pkg::*;

  logic [1:0]  q_s  [0:5];
  logic [30:0] t_s  [0:4];
  logic [30:0] t2_s [0:3];
  poly_t       r_s  [1:4];
  poly_t       sr;

  logic [14:0] xf;
  logic [30:0] t0;
  logic [61:0] tt;
  logic [30:0] sc;
  logic [30:0] rnd;

  assign xf = phase[14] ? 15'(15'h4000 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
  assign t0 = {xf[14:0], 16'b0};
  assign tt = 62'(t0) * 62'(t0);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q_s[0]  <= phase[15:14];
      t_s[0]  <= t0;
      t2_s[0] <= tt[60:30];
    end
  end

  for (genvar k = 1; k <= 4; k++) begin : g_horner
    poly_t r_in;
    if (k == 1) begin : g_first
      assign r_in = C9;
    end else begin : g_rest
      assign r_in = r_s[k-1];
    end
    always_ff @(posedge clk) begin
      if (en[k]) begin
        r_s[k] <= HORNER_C[k-1] + mul_q30(r_in, t2_s[k-1]);
        q_s[k] <= q_s[k-1];
        t_s[k] <= t_s[k-1];
      end
    end
    if (k < 4) begin : g_t2
      always_ff @(posedge clk) begin
        if (en[k]) begin
          t2_s[k] <= t2_s[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sr     <= mul_q30(r_s[4], t_s[4]);
      q_s[5] <= q_s[4];
    end
  end

  always_comb begin
    if (sr[33]) begin
      sc = '0;
    end else if (sr > 34'sd1073741824) begin
      sc = 31'h4000_0000;
    end else begin
      sc = sr[30:0];
    end
    rnd = sc + 31'h2000;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      sv <= q_s[5][1] ? trig_t'(-$signed({1'b0, rnd[30:14]})) : trig_t'({1'b0, rnd[30:14]});
    end
  end

endmodule

[rtl/pua_crd.sv]
// Source coordinate stages: scale by radius and aspect ratio, center, clamp, byte offset.
// Depends on pua_pkg.
module pua_crd (
  input  logic                        clk,
  input  logic [pua_pkg::CRD_STG-1:0] en,
  input  pua_pkg::trig_t              sv,
  input  pua_pkg::trig_t              cv,
  input  logic [15:0]                 amp,
  input  logic                        flag_in,
  input  logic [15:0]                 center_u,
  input  logic [15:0]                 center_v,
  input  logic [15:0]                 aspect_ratio,
  output logic [10:0]                 src_x,
  output logic [10:0]                 src_y,
  output logic [23:0]                 src_byte_offset,
  output logic                        clamped
);
  import pua_pkg::*;

  logic signed [34:0] pc;
  logic signed [34:0] ps;
  logic               f0;
  logic signed [51:0] pq;
  logic signed [13:0] xs;
  logic               f1;
  logic [10:0]        xc;
  logic signed [17:0] ys;
  logic               f2;

  logic signed [34:0] xf;
  logic [16:0]        ucomp;
  logic signed [38:0] yf;
  logic               xlo;
  logic               xhi;
  logic               ylo;
  logic               yhi;
  logic [10:0]        yc;
  logic [23:0]        lin;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pc <= 35'(cv) * 35'($signed({1'b0, amp}));
      ps <= 35'(sv) * 35'($signed({1'b0, amp}));
      f0 <= flag_in;
    end
  end

  assign xf = $signed({3'b0, center_v, 16'b0}) - pc;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pq <= 52'($signed({1'b0, aspect_ratio})) * 52'(ps);
      xs <= xf[34:21];
      f1 <= f0;
    end
  end

  assign ucomp = 17'(17'h10000 - {1'b0, center_u});
  assign yf    = $signed({6'b0, ucomp, 16'b0}) - 39'($signed(pq[51:14]));
  assign xlo   = xs[13];
  assign xhi   = !xs[13] && (xs[12:11] != 2'b00);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      xc <= xlo ? '0 : (xhi ? 11'h7FF : xs[10:0]);
      ys <= yf[38:21];
      f2 <= f1 || xlo || xhi;
    end
  end

  assign ylo = ys[17];
  assign yhi = !ys[17] && (ys[16:11] != '0);
  assign yc  = ylo ? '0 : (yhi ? 11'h7FF : ys[10:0]);
  assign lin = {2'b0, yc, xc};

  always_ff @(posedge clk) begin
    if (en[3]) begin
      src_x           <= xc;
      src_y           <= yc;
      src_byte_offset <= 24'({lin[22:0], 1'b0} + lin);
      clamped         <= f2 || ylo || yhi;
    end
  end

endmodule
